FILE: src/xpf_pkg.sv
// ----------------------------------------------------------------------------
// xpf_pkg
// Shared sizes, field widths and state encoding of the XOR parity decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package xpf_pkg;

  localparam int MAX_GROUP = 8;
  localparam int MAX_FRAME = 1024;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 11;                       // frame_len field
  localparam int SLOT_IN_W = 4;                      // slot field
  localparam int GS_W    = 4;                        // frames-per-group register
  localparam int RSLOT_W = 3;                        // recovered_slot field
  localparam int SLOT_W  = $clog2(MAX_GROUP);
  localparam int POS_W   = $clog2(MAX_FRAME);
  localparam int ADDR_W  = SLOT_W + POS_W;
  localparam int STORE_DEPTH = MAX_GROUP * MAX_FRAME;

  localparam int IN_TDATA_W  = ((BYTE_W + LEN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = BYTE_W;
  localparam int OUT_TUSER_W = 1 + RSLOT_W + 1;

  localparam logic [GS_W-1:0] GS_RESET = GS_W'(3);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

FILE: src/xor_parity_fec_decoder_core.sv
// ----------------------------------------------------------------------------
// xor_parity_fec_decoder_core
// Byte-serial XOR parity FEC decoder: stores data frames, rebuilds one lost
// frame of a group from its parity frame, one result beat per input beat.
// ----------------------------------------------------------------------------
// Sequence: a pass-through or rejected beat goes IDLE -> EMIT -> output register;
//   a recovered parity beat goes IDLE -> RUN (a slot per step) -> FLUSH -> EMIT.
// Flow: a new input beat is taken only after the last result is loaded; a
//   rebuild is paced by the single frame store read port, one slot/cycle.
// Reset (rst_n low, synchronous): sequencer, marks, lengths, position and
//   group size (back to 3) cleared; the frame store keeps its contents.
`default_nettype none

module xor_parity_fec_decoder_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // config
  input  wire logic                                cfg_we,
  input  wire logic [xpf_pkg::GS_W-1:0]            cfg_wdata,   // frames per group
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [xpf_pkg::IN_TDATA_W-1:0]      in_tdata,    // data_byte, frame_len, pad
  input  wire logic [xpf_pkg::SLOT_IN_W-1:0]       in_tuser,    // slot
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [xpf_pkg::OUT_TDATA_W-1:0]          out_tdata,   // out_byte
  output logic [xpf_pkg::OUT_TUSER_W-1:0]          out_tuser,   // recovered, recovered_slot, rejected
  output logic                                     out_tlast    // last_of_frame
);

  localparam int MG = xpf_pkg::MAX_GROUP;

  // --------------------------------------------------------------------------
  // Configuration: out-of-range group sizes are dropped
  // --------------------------------------------------------------------------
  logic [xpf_pkg::GS_W-1:0] gs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r <= xpf_pkg::GS_RESET;
    end else if (cfg_we && (cfg_wdata != '0) &&
                 ({1'b0, cfg_wdata} <= (xpf_pkg::GS_W+1)'(MG))) begin
      gs_r <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Persistent decoder state
  // --------------------------------------------------------------------------
  xpf_pkg::state_t state_r, state_nxt;

  logic [xpf_pkg::POS_W-1:0]  pos_r, pos_nxt;       // next byte within frame
  logic [MG-1:0]              mask_r, mask_nxt;     // received marks
  logic                       rec_act_r, rec_act_nxt;
  logic [xpf_pkg::SLOT_W-1:0] miss_r, miss_nxt;
  logic [xpf_pkg::LEN_W-1:0]  len_r [MG];           // stored frame lengths

  // per-beat working registers
  logic [xpf_pkg::BYTE_W-1:0] acc_r, acc_nxt;       // pass-through / XOR accumulator
  logic [xpf_pkg::POS_W-1:0]  pos_q_r;
  logic [xpf_pkg::SLOT_W-1:0] miss_q_r;
  logic                       rec_q_r, last_q_r, rej_q_r;
  logic [xpf_pkg::SLOT_W-1:0] idx_r, idx_nxt;       // slot being read
  logic                       rd_pend_r, take_r;

  // output register
  logic                       out_valid_r;
  logic [xpf_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_rec_r, out_last_r, out_rej_r;
  logic [xpf_pkg::RSLOT_W-1:0] out_rslot_r;

  // --------------------------------------------------------------------------
  // Input beat decode
  // --------------------------------------------------------------------------
  logic [xpf_pkg::BYTE_W-1:0]    in_byte;
  logic [xpf_pkg::LEN_W-1:0]     in_len;
  logic [xpf_pkg::SLOT_IN_W-1:0] in_slot;
  logic [xpf_pkg::SLOT_W-1:0]    slot_idx;
  logic                          accept, bad, is_data, last;
  logic [MG-1:0]                 grp, unmarked;
  logic                          rec_now, rec_use;
  logic [xpf_pkg::SLOT_W-1:0]    miss_now, miss_use;

  assign in_byte  = in_tdata[xpf_pkg::BYTE_W-1:0];
  assign in_len   = in_tdata[xpf_pkg::BYTE_W +: xpf_pkg::LEN_W];
  assign in_slot  = in_tuser;
  assign slot_idx = in_slot[xpf_pkg::SLOT_W-1:0];

  assign in_tready = (state_r == xpf_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign bad = (in_slot > gs_r) || (in_len == '0) ||
               (in_len > xpf_pkg::LEN_W'(xpf_pkg::MAX_FRAME));
  assign is_data = (in_slot < gs_r);
  // a shrinking length mid-frame also ends the frame
  assign last = (xpf_pkg::LEN_W'(pos_r) + xpf_pkg::LEN_W'(1)) >= in_len;

  // only marks below the group size take part in the recovery decision
  always_comb begin
    grp      = '0;
    miss_now = '0;
    for (int k = 0; k < MG; k++) begin
      grp[k] = (xpf_pkg::GS_W'(k) < gs_r);
    end
    unmarked = grp & ~mask_r;
    for (int k = 0; k < MG; k++) begin
      if (unmarked[k]) begin
        miss_now = xpf_pkg::SLOT_W'(k);
      end
    end
  end

  assign rec_now  = $onehot(unmarked);
  // decision taken on the first parity byte, held for the frame
  assign rec_use  = (pos_r == '0) ? rec_now : rec_act_r;
  assign miss_use = (pos_r == '0) ? (rec_now ? miss_now : '0) : miss_r;

  // --------------------------------------------------------------------------
  // Frame store
  // --------------------------------------------------------------------------
  logic                        ram_we;
  logic [xpf_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [xpf_pkg::BYTE_W-1:0]  ram_rdata;

  assign ram_we    = accept && !bad && is_data;
  assign ram_waddr = {slot_idx, pos_r};
  assign ram_raddr = {idx_r, pos_q_r};

  xpf_ram #(
    .WIDTH (xpf_pkg::BYTE_W),
    .DEPTH (xpf_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_byte),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic out_load;
  logic idx_end;

  assign out_load = (state_r == xpf_pkg::ST_EMIT) && (!out_valid_r || out_tready);
  assign idx_end  = ((xpf_pkg::GS_W'(idx_r) + xpf_pkg::GS_W'(1)) == gs_r);

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    mask_nxt    = mask_r;
    rec_act_nxt = rec_act_r;
    miss_nxt    = miss_r;
    acc_nxt     = acc_r;
    idx_nxt     = idx_r;

    if (rd_pend_r && take_r) begin
      acc_nxt = acc_r ^ ram_rdata;
    end

    unique case (state_r)
      xpf_pkg::ST_IDLE: begin
        if (accept) begin
          acc_nxt = in_byte;
          idx_nxt = '0;
          if (bad) begin
            state_nxt = xpf_pkg::ST_EMIT;
          end else begin
            pos_nxt = last ? '0 : pos_r + xpf_pkg::POS_W'(1);
            if (is_data) begin
              mask_nxt[slot_idx] = 1'b1;
              state_nxt = xpf_pkg::ST_EMIT;
            end else begin
              rec_act_nxt = rec_use;
              miss_nxt    = miss_use;
              state_nxt   = rec_use ? xpf_pkg::ST_RUN : xpf_pkg::ST_EMIT;
              if (last) begin
                mask_nxt    = '0;
                rec_act_nxt = 1'b0;
                miss_nxt    = '0;
              end
            end
          end
        end
      end
      xpf_pkg::ST_RUN: begin
        idx_nxt = idx_r + xpf_pkg::SLOT_W'(1);
        if (idx_end) begin
          state_nxt = xpf_pkg::ST_FLUSH;
        end
      end
      xpf_pkg::ST_FLUSH: begin
        state_nxt = xpf_pkg::ST_EMIT;
      end
      xpf_pkg::ST_EMIT: begin
        if (out_load) begin
          state_nxt = xpf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = xpf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= xpf_pkg::ST_IDLE;
      pos_r     <= '0;
      mask_r    <= '0;
      rec_act_r <= 1'b0;
      miss_r    <= '0;
      rd_pend_r <= 1'b0;
      for (int k = 0; k < MG; k++) begin
        len_r[k] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      mask_r    <= mask_nxt;
      rec_act_r <= rec_act_nxt;
      miss_r    <= miss_nxt;
      rd_pend_r <= (state_r == xpf_pkg::ST_RUN);
      if (ram_we) begin
        len_r[slot_idx] <= in_len;
      end
    end
  end

  // beat registers, no reset needed
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    idx_r <= idx_nxt;
    // skip the lost slot and frames too short to reach this position
    take_r <= (idx_r != miss_q_r) &&
              (xpf_pkg::LEN_W'(pos_q_r) < len_r[idx_r]);
    if (accept) begin
      pos_q_r  <= pos_r;
      miss_q_r <= miss_use;
      rec_q_r  <= !bad && !is_data && rec_use;
      last_q_r <= !bad && last;
      rej_q_r  <= bad;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r  <= rej_q_r ? '0 : acc_r;
      out_rec_r   <= rec_q_r;
      out_rslot_r <= rec_q_r ? xpf_pkg::RSLOT_W'(miss_q_r) : '0;
      out_last_r  <= last_q_r;
      out_rej_r   <= rej_q_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_rej_r, out_rslot_r, out_rec_r};
  assign out_tlast  = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_store_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == xpf_pkg::ST_IDLE))
    else $error("frame store written outside idle");

  a_miss_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    !rec_act_r |-> (miss_r == '0))
    else $error("missing slot held without active recovery");

  a_rej_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |-> (!out_rec_r && !out_last_r && (out_byte_r == '0)))
    else $error("rejected beat carries data");

  a_read_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == xpf_pkg::ST_RUN || state_r == xpf_pkg::ST_FLUSH))
    else $error("store read returned outside recovery");

endmodule

`default_nettype wire

FILE: src/xpf_ram.sv
// ----------------------------------------------------------------------------
// xpf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module xpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
